// ----- src/lau_pkg.sv -----
// shared types and constants of the levels adjustment unit
package lau_pkg;

    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 3;
    localparam int NUM_W    = 17;
    localparam int DEN_W    = 9;
    localparam int QUOT_W   = 8;
    localparam int IDX_W    = 2;

    localparam logic [IDX_W-1:0] REG_IN_BLACK  = 2'd0;
    localparam logic [IDX_W-1:0] REG_IN_WHITE  = 2'd1;
    localparam logic [IDX_W-1:0] REG_OUT_BLACK = 2'd2;
    localparam logic [IDX_W-1:0] REG_OUT_WHITE = 2'd3;

    typedef enum logic [1:0] {
        CLS_BLACK,
        CLS_WHITE,
        CLS_INTERP
    } lvl_class_t;

    typedef struct packed {
        logic [CHAN_W-1:0] in_black;
        logic [CHAN_W-1:0] in_white;
        logic [CHAN_W-1:0] out_black;
        logic [CHAN_W-1:0] out_white;
    } levels_cfg_t;

    // per-channel work item passed from front to back
    typedef struct packed {
        lvl_class_t       cls;
        logic [NUM_W-1:0] num;
    } chan_work_t;

    typedef chan_work_t [NUM_CHAN-1:0] work_t;

endpackage

// ----- src/lau_front.sv -----
// front end: accepts pixels, classifies channels and forms the rounding dividend
module lau_front
    import lau_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  levels_cfg_t                  cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [NUM_CHAN*CHAN_W-1:0]   in_data,
    output logic                         push,
    output work_t                        push_data,
    input  logic                         queue_full
);

    typedef struct packed {
        lvl_class_t        cls;
        logic [CHAN_W-1:0] dx;
    } chan_cls_t;

    logic                               s1_valid_reg;
    chan_cls_t [NUM_CHAN-1:0]           s1_data_reg;
    chan_cls_t [NUM_CHAN-1:0]           s1_data_next;
    logic                               s2_valid_reg;
    work_t                              s2_data_reg;
    work_t                              s2_data_next;
    logic                               adv1;
    logic                               adv2;
    logic [CHAN_W-1:0]                  span;

    assign adv2     = !s2_valid_reg || !queue_full;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_ready = adv1;
    assign push     = s2_valid_reg && !queue_full;
    assign push_data = s2_data_reg;

    // white test first, so a collapsed input range never interpolates
    always_comb
    begin
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            logic [CHAN_W-1:0] x;
            x = in_data[i*CHAN_W +: CHAN_W];
            s1_data_next[i].dx = x - cfg.in_black;
            if (x >= cfg.in_white)
                s1_data_next[i].cls = CLS_WHITE;
            else if (x <= cfg.in_black)
                s1_data_next[i].cls = CLS_BLACK;
            else
                s1_data_next[i].cls = CLS_INTERP;
        end
    end

    assign span = cfg.in_white - cfg.in_black;

    // num = 2*(ob*(d-dx) + ow*dx) + d, quotient by 2*d rounds half up
    always_comb
    begin
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            logic [CHAN_W-1:0]   rest;
            logic [2*CHAN_W-1:0] p_lo;
            logic [2*CHAN_W-1:0] p_hi;
            logic [NUM_W-1:0]    t_sum;
            rest  = span - s1_data_reg[i].dx;
            p_lo  = cfg.out_black * rest;
            p_hi  = cfg.out_white * s1_data_reg[i].dx;
            t_sum = {1'b0, p_lo} + {1'b0, p_hi};
            s2_data_next[i].cls = s1_data_reg[i].cls;
            s2_data_next[i].num = {t_sum[NUM_W-2:0], 1'b0} + {{(NUM_W-CHAN_W){1'b0}}, span};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_valid_reg <= in_valid;
            if (adv2)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
            s1_data_reg <= s1_data_next;
        if (adv2)
            s2_data_reg <= s2_data_next;
    end

endmodule

// ----- src/lau_queue.sv -----
// short fifo between front and back ends
module lau_queue
    import lau_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_data,
    input  logic  pop,
    output work_t head_data,
    output logic  full,
    output logic  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    work_t             mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_data = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- src/lau_back.sv -----
// back end: restoring divider pipeline, one quotient bit per stage, and output select
module lau_back
    import lau_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  levels_cfg_t                  cfg,
    input  logic                         queue_empty,
    input  work_t                        head_data,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [NUM_CHAN*CHAN_W-1:0]   out_data
);

    localparam int STAGES = QUOT_W;

    logic [STAGES-1:0]                   v_reg;
    lvl_class_t [NUM_CHAN-1:0]           cls_reg  [STAGES];
    logic [NUM_CHAN-1:0][NUM_W-1:0]      rem_reg  [STAGES];
    logic [NUM_CHAN-1:0][QUOT_W-1:0]     quot_reg [STAGES];
    logic [NUM_CHAN-1:0][NUM_W-1:0]      rem_next [STAGES];
    logic [NUM_CHAN-1:0][QUOT_W-1:0]     quot_next[STAGES];
    logic [DEN_W-1:0]                    den;
    logic                                adv;

    assign den       = {cfg.in_white - cfg.in_black, 1'b0};
    assign adv       = !v_reg[STAGES-1] || out_ready;
    assign pop       = adv && !queue_empty;
    assign out_valid = v_reg[STAGES-1];

    // stage s settles quotient bit STAGES-1-s
    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        localparam int SH = STAGES - 1 - s;
        always_comb
        begin
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                logic [NUM_W-1:0]  rem_in;
                logic [QUOT_W-1:0] quot_in;
                logic [NUM_W-1:0]  trial;
                if (s == 0)
                begin
                    rem_in  = head_data[c].num;
                    quot_in = '0;
                end
                else
                begin
                    rem_in  = rem_reg[(s > 0) ? s - 1 : 0][c];
                    quot_in = quot_reg[(s > 0) ? s - 1 : 0][c];
                end
                trial = {{(NUM_W-DEN_W){1'b0}}, den} << SH;
                if (rem_in >= trial)
                begin
                    rem_next[s][c]  = rem_in - trial;
                    quot_next[s][c] = {quot_in[QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[s][c]  = rem_in;
                    quot_next[s][c] = {quot_in[QUOT_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[STAGES-2:0], !queue_empty};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                quot_reg[s] <= quot_next[s];
                if (s == 0)
                begin
                    for (int c = 0; c < NUM_CHAN; c++)
                        cls_reg[0][c] <= head_data[c].cls;
                end
                else
                    cls_reg[s] <= cls_reg[(s > 0) ? s - 1 : 0];
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            unique case (cls_reg[STAGES-1][c])
                CLS_WHITE:  out_data[c*CHAN_W +: CHAN_W] = cfg.out_white;
                CLS_BLACK:  out_data[c*CHAN_W +: CHAN_W] = cfg.out_black;
                CLS_INTERP: out_data[c*CHAN_W +: CHAN_W] = quot_reg[STAGES-1][c];
                default:    out_data[c*CHAN_W +: CHAN_W] = cfg.out_black;
            endcase
        end
    end

endmodule

// ----- src/levels_adjustment_unit.sv -----
// top level of the levels adjustment unit: config registers, front, queue and back
//
// Maps each of the three 8-bit channels of a pixel through one levels curve set by
// in_black, in_white, out_black and out_white (register indexes 0 to 3). A channel at or
// above in_white gives out_white, otherwise at or below in_black gives out_black, and in
// between the linear interpolation rounded to nearest with halves rounded up. The unit
// takes one pixel per clock while the output is drained; a pixel reaches the master side
// after the two front stages, the queue hand-over and the eight-stage divider that
// resolves one quotient bit per stage. The queue of QUEUE_DEPTH entries lets front and
// back stall independently. Write the registers only while no pixel is in flight.
module levels_adjustment_unit
    import lau_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [NUM_CHAN*CHAN_W-1:0]   s_axis_tdata,   // chan_a_in, chan_b_in, chan_c_in
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [NUM_CHAN*CHAN_W-1:0]   m_axis_tdata,   // chan_a_out, chan_b_out, chan_c_out
    input  logic                         cfg_we,
    input  logic [IDX_W-1:0]             cfg_index,
    input  logic [CHAN_W-1:0]            cfg_data
);

    levels_cfg_t cfg_reg;
    logic        push;
    work_t       push_data;
    logic        pop;
    work_t       head_data;
    logic        queue_full;
    logic        queue_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.in_black  <= 8'd0;
            cfg_reg.in_white  <= 8'd255;
            cfg_reg.out_black <= 8'd0;
            cfg_reg.out_white <= 8'd255;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IN_BLACK:  cfg_reg.in_black  <= cfg_data;
                REG_IN_WHITE:  cfg_reg.in_white  <= cfg_data;
                REG_OUT_BLACK: cfg_reg.out_black <= cfg_data;
                REG_OUT_WHITE: cfg_reg.out_white <= cfg_data;
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    lau_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    lau_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    lau_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .queue_empty (queue_empty),
        .head_data   (head_data),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata)
    );

endmodule

// ----- src/lau_checker.sv -----
// port-level assertions for the levels adjustment unit and their bind
module lau_checker
    import lau_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [NUM_CHAN*CHAN_W-1:0]   m_axis_tdata
);

    // two front stages, the queue and the divider stages
    localparam int CAPACITY = QUEUE_DEPTH + 2 + QUOT_W;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] pending_reg;
    logic             in_txn;
    logic             out_txn;

    assign in_txn  = s_axis_tvalid && s_axis_tready;
    assign out_txn = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (in_txn && !out_txn)
            pending_reg <= pending_reg + 1'b1;
        else if (out_txn && !in_txn)
            pending_reg <= pending_reg - 1'b1;
    end

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != '0)
        else $error("output transaction without a pending input");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == CNT_W'(CAPACITY) |-> !s_axis_tready)
        else $error("input accepted with every slot occupied");

endmodule

bind levels_adjustment_unit lau_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_lau_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- bench/levels_adjustment_unit_test.sv -----
// self-checking stream testbench for the levels adjustment unit
module levels_adjustment_unit_test
    import lau_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 30;

    typedef struct packed {
        logic [CHAN_W-1:0] chan_c;
        logic [CHAN_W-1:0] chan_b;
        logic [CHAN_W-1:0] chan_a;
    } pixel_t;

    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [NUM_CHAN*CHAN_W-1:0] s_axis_tdata;   // chan_a_in, chan_b_in, chan_c_in
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [NUM_CHAN*CHAN_W-1:0] m_axis_tdata;   // chan_a_out, chan_b_out, chan_c_out
    logic                       cfg_we;
    logic [IDX_W-1:0]           cfg_index;
    logic [CHAN_W-1:0]          cfg_data;

    // own copy of the curve registers
    int lvl_in_black;
    int lvl_in_white;
    int lvl_out_black;
    int lvl_out_white;

    pixel_t pending_pixels[$];
    pixel_t expected_pixels[$];
    logic   in_taken;
    logic   idling_on;
    int     in_gap;
    int     out_gap;
    int     mismatch_count;
    int     cycle_count;

    levels_adjustment_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [CHAN_W-1:0] level_of(logic [CHAN_W-1:0] x);
        int xv;
        int span;
        int num;
        int q;
        xv = x;
        if (xv >= lvl_in_white)
            return CHAN_W'(lvl_out_white);
        if (xv <= lvl_in_black)
            return CHAN_W'(lvl_out_black);
        span = lvl_in_white - lvl_in_black;
        num  = lvl_out_black * span + (xv - lvl_in_black) * (lvl_out_white - lvl_out_black);
        if (num < 0)
            num = 0;
        // nearest, halves rounded up
        q = (2 * num + span) / (2 * span);
        if (q > 255)
            q = 255;
        return CHAN_W'(q);
    endfunction

    function automatic pixel_t levels_pixel(pixel_t p);
        pixel_t r;
        r.chan_a = level_of(p.chan_a);
        r.chan_b = level_of(p.chan_b);
        r.chan_c = level_of(p.chan_c);
        return r;
    endfunction

    function automatic logic [CHAN_W-1:0] pick_level();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    // bias some channels towards the black and white points
    function automatic logic [CHAN_W-1:0] rand_level();
        case ($urandom_range(0, 7))
            0: return CHAN_W'(lvl_in_black + $urandom_range(0, 2) - 1);
            1: return CHAN_W'(lvl_in_white + $urandom_range(0, 2) - 1);
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    task automatic push_pixel(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
                              logic [CHAN_W-1:0] c);
        pixel_t p;
        p.chan_a = a;
        p.chan_b = b;
        p.chan_c = c;
        pending_pixels.push_back(p);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CHAN_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_IN_BLACK:  lvl_in_black  = value;
            REG_IN_WHITE:  lvl_in_white  = value;
            REG_OUT_BLACK: lvl_out_black = value;
            REG_OUT_WHITE: lvl_out_white = value;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_levels(logic [CHAN_W-1:0] ib, logic [CHAN_W-1:0] iw,
                              logic [CHAN_W-1:0] ob, logic [CHAN_W-1:0] ow);
        write_reg(REG_IN_BLACK, ib);
        write_reg(REG_IN_WHITE, iw);
        write_reg(REG_OUT_BLACK, ob);
        write_reg(REG_OUT_WHITE, ow);
    endtask

    // sender held back until every expected pixel is out
    task automatic drain_pipeline();
        @(posedge clk);
        while (pending_pixels.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    // input driver
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_pixels.size() != 0 && idling_on && $urandom_range(0, 9) == 0)
            begin
                in_gap = $urandom_range(0, 4);
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_pixels.size() != 0)
            begin
                s_axis_tdata  <= pending_pixels.pop_front();
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_gap > 0)
            begin
                out_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                out_gap = $urandom_range(0, 4);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // monitor: predict on each input transaction, check each output transaction
    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (rst_n)
        begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
                expected_pixels.push_back(levels_pixel(pixel_t'(s_axis_tdata)));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = pixel_t'(m_axis_tdata);
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch("unexpected output transaction", got, 0);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.chan_a !== want.chan_a)
                        report_mismatch("chan_a_out", got.chan_a, want.chan_a);
                    if (got.chan_b !== want.chan_b)
                        report_mismatch("chan_b_out", got.chan_b, want.chan_b);
                    if (got.chan_c !== want.chan_c)
                        report_mismatch("chan_c_out", got.chan_c, want.chan_c);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("levels_adjustment_unit test failed");
            $finish;
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_IN_BLACK;
        cfg_data       = '0;
        in_taken       = 1'b0;
        idling_on      = 1'b1;
        in_gap         = 0;
        out_gap        = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        lvl_in_black   = 0;
        lvl_in_white   = 255;
        lvl_out_black  = 0;
        lvl_out_white  = 255;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // curve as it comes out of reset
        push_pixel(8'd0, 8'd0, 8'd0);
        push_pixel(8'd255, 8'd255, 8'd255);
        push_pixel(8'd1, 8'd128, 8'd254);
        push_pixel(8'h55, 8'hAA, 8'h0F);
        drain_pipeline();
        set_levels(8'd16, 8'd235, 8'd0, 8'd255);
        push_pixel(8'd16, 8'd17, 8'd234);
        push_pixel(8'd235, 8'd15, 8'd255);
        drain_pipeline();
        // falling curve
        set_levels(8'd20, 8'd220, 8'd255, 8'd0);
        push_pixel(8'd20, 8'd21, 8'd219);
        push_pixel(8'd220, 8'd120, 8'd0);
        drain_pipeline();
        // exact halves, rising then falling
        set_levels(8'd0, 8'd2, 8'd0, 8'd1);
        push_pixel(8'd1, 8'd0, 8'd2);
        drain_pipeline();
        set_levels(8'd0, 8'd2, 8'd1, 8'd0);
        push_pixel(8'd1, 8'd2, 8'd0);
        drain_pipeline();
        // white point below black point
        set_levels(8'd200, 8'd50, 8'd30, 8'd90);
        push_pixel(8'd50, 8'd49, 8'd200);
        push_pixel(8'd201, 8'd0, 8'd255);
        drain_pipeline();
        // white point equal to black point
        set_levels(8'd128, 8'd128, 8'd7, 8'd9);
        push_pixel(8'd127, 8'd128, 8'd129);
        drain_pipeline();
        set_levels(8'd255, 8'd0, 8'd255, 8'd255);
        push_pixel(8'd0, 8'd255, 8'd128);
        drain_pipeline();
        set_levels(8'd0, 8'd255, 8'd255, 8'd0);
        push_pixel(8'd0, 8'd255, 8'd1);
        push_pixel(8'd254, 8'd127, 8'd128);
        drain_pipeline();
        set_levels(8'd254, 8'd255, 8'd0, 8'd255);
        push_pixel(8'd254, 8'd255, 8'd253);
        drain_pipeline();
        set_levels(8'd0, 8'd1, 8'd255, 8'd0);
        push_pixel(8'd0, 8'd1, 8'd255);
        drain_pipeline();
        // flat output
        set_levels(8'd100, 8'd200, 8'd50, 8'd50);
        push_pixel(8'd150, 8'd101, 8'd199);

        for (int phase = 0; phase < 10; phase++)
        begin
            drain_pipeline();
            set_levels(pick_level(), pick_level(), pick_level(), pick_level());
            // quiet stretches on some phases, none in the last
            idling_on = (phase < 9) && (phase % 3 != 1);
            repeat (85)
                push_pixel(rand_level(), rand_level(), rand_level());
        end

        drain_pipeline();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("levels_adjustment_unit test passed");
        else
            $display("levels_adjustment_unit test failed");
        $finish;
    end

endmodule
